// ===== design/hbke_pkg.sv =====
// Shared types, codes and helpers of the Hamming-ball k-mer enumerator.
// Depends on nothing; every other file of the block imports it.
package hbke_pkg;

  localparam int FIELD_W         = 60;
  localparam int DIGIT_W         = 3;
  localparam int KMER_LEN_DEF    = 20;
  localparam int MAX_CHANGES_DEF = 4;

  localparam logic [DIGIT_W-1:0] CODE_A = 3'd1;
  localparam logic [DIGIT_W-1:0] CODE_C = 3'd2;
  localparam logic [DIGIT_W-1:0] CODE_G = 3'd4;
  localparam logic [DIGIT_W-1:0] CODE_T = 3'd7;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_NEXT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] kmer_code;
  } hbke_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] variation;
    logic               is_last;
    logic               none_left;
  } hbke_res_t;

  // Operations of the digit rotators.
  typedef enum logic [2:0] {
    SH_HOLD,
    SH_LOAD,
    SH_RIGHT,
    SH_LEFT,
    SH_SET0
  } sh_op_e;

  typedef struct packed {
    sh_op_e             op;
    logic [DIGIT_W-1:0] digit;
  } sh_ctrl_t;

  // Digits the sequencer looks at: the current slot and the top slot.
  typedef struct packed {
    logic [DIGIT_W-1:0] v0;
    logic [DIGIT_W-1:0] k0;
    logic [DIGIT_W-1:0] ktop;
  } sh_view_t;

  function automatic logic is_base(input logic [DIGIT_W-1:0] c);
    return (c == CODE_A) || (c == CODE_C) || (c == CODE_G) || (c == CODE_T);
  endfunction

endpackage

// ===== design/hamming_ball_kmer_enumerator.sv =====
// Top level of the Hamming-ball k-mer enumerator.
// Depends on hbke_pkg; instantiates hbke_shift and hbke_seq.
//
// Usage. A request item is accepted at a rising edge where start is high and
// busy is low. A load item (req_type 0) takes a new k-mer and answers with the
// smallest member of its neighborhood; a next item (req_type 1) answers with
// the member that follows the last one given. Every item gives exactly one
// result item, shown on res_o for a single cycle while res_valid_o is high.
// The receiver cannot stall, so a result is simply gone after its cycle.
//
// Timing. A next item after the last member, or before any load, answers in
// the cycle after acceptance. Any other next item runs a setup step, a scan
// up to the position at which the successor scan finds its increment, and a
// fill back down from there. A load counts the bases of the k-mer, builds the
// smallest member, and then runs the same setup, scan and fill as a next item
// to learn whether that member is the last one. Each count, scan or fill step
// handles one 3-bit position of the rotating digit registers.
// Busy stays high while an item is at work and falls in the cycle its result
// is shown. Reset clears the control state and leaves no k-mer loaded.
module hamming_ball_kmer_enumerator import hbke_pkg::*; #(
  parameter int KMER_LEN    = KMER_LEN_DEF,
  parameter int MAX_CHANGES = MAX_CHANGES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  hbke_req_t req_i,
  output logic      busy,
  output logic      res_valid_o,
  output hbke_res_t res_o
);

  sh_ctrl_t                    sh_ctrl;
  sh_view_t                    sh_view;
  logic [DIGIT_W*KMER_LEN-1:0] rot_v;

  // The rotators hold the k-mer and the working member, one position per slot.
  hbke_shift #(
    .KMER_LEN (KMER_LEN)
  ) u_shift (
    .clk_i   (clk_i),
    .ctrl_i  (sh_ctrl),
    .kmer_i  (req_i.kmer_code),
    .view_o  (sh_view),
    .rot_v_o (rot_v)
  );

  // The sequencer steps the rotators and owns the result register.
  hbke_seq #(
    .KMER_LEN    (KMER_LEN),
    .MAX_CHANGES (MAX_CHANGES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .sh_ctrl_o   (sh_ctrl),
    .view_i      (sh_view),
    .rot_v_i     (rot_v)
  );

endmodule

// ===== design/hbke_shift.sv =====
// Rotating digit registers that hold the k-mer and the working variation.
// Depends on hbke_pkg for the control and view types.
module hbke_shift import hbke_pkg::*; #(
  parameter int KMER_LEN = KMER_LEN_DEF
) (
  input  logic                          clk_i,
  input  sh_ctrl_t                      ctrl_i,
  input  logic [FIELD_W-1:0]            kmer_i,
  output sh_view_t                      view_o,
  output logic [DIGIT_W*KMER_LEN-1:0]   rot_v_o
);

  localparam int VW = DIGIT_W * KMER_LEN;

  logic [VW-1:0]         rot_v_q, rot_v_d;
  logic [VW-1:0]         rot_k_q, rot_k_d;
  logic [VW+FIELD_W-1:0] kmer_pad;

  // Bits above the k-mer are dropped; missing bits read as zero.
  assign kmer_pad = {{VW{1'b0}}, kmer_i};

  always_comb begin
    rot_v_d = rot_v_q;
    rot_k_d = rot_k_q;
    unique case (ctrl_i.op)
      SH_LOAD: begin
        rot_v_d = '0;
        rot_k_d = kmer_pad[VW-1:0];
      end
      SH_RIGHT: begin
        rot_v_d = {rot_v_q[DIGIT_W-1:0], rot_v_q[VW-1:DIGIT_W]};
        rot_k_d = {rot_k_q[DIGIT_W-1:0], rot_k_q[VW-1:DIGIT_W]};
      end
      SH_LEFT: begin
        rot_v_d = {rot_v_q[VW-DIGIT_W-1:0], ctrl_i.digit};
        rot_k_d = {rot_k_q[VW-DIGIT_W-1:0], rot_k_q[VW-1:VW-DIGIT_W]};
      end
      SH_SET0: begin
        rot_v_d = {rot_v_q[VW-1:DIGIT_W], ctrl_i.digit};
      end
      default: begin
        rot_v_d = rot_v_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rot_v_q <= rot_v_d;
    rot_k_q <= rot_k_d;
  end

  assign view_o.v0   = rot_v_q[DIGIT_W-1:0];
  assign view_o.k0   = rot_k_q[DIGIT_W-1:0];
  assign view_o.ktop = rot_k_q[VW-1:VW-DIGIT_W];
  assign rot_v_o     = rot_v_q;

endmodule

// ===== design/hbke_pick.sv =====
// Digit chooser: smallest legal code at one position that still allows completion.
// Depends on hbke_pkg for the base-code test.
module hbke_pick import hbke_pkg::*; #(
  parameter int KMER_LEN    = KMER_LEN_DEF,
  parameter int MAX_CHANGES = MAX_CHANGES_DEF
) (
  input  logic [DIGIT_W-1:0]                          kc_i,
  input  logic [DIGIT_W:0]                            floor_i,
  input  logic [$clog2(KMER_LEN+MAX_CHANGES+2)-1:0]   d_i,
  input  logic [$clog2(KMER_LEN+MAX_CHANGES+2)-1:0]   n_i,
  input  logic [$clog2(KMER_LEN+MAX_CHANGES+2)-1:0]   bb_i,
  input  logic [$clog2(KMER_LEN+MAX_CHANGES+2)-1:0]   ob_i,
  output logic                                        found_o,
  output logic [DIGIT_W-1:0]                          code_o,
  output logic [$clog2(KMER_LEN+MAX_CHANGES+2)-1:0]   d_o,
  output logic [$clog2(KMER_LEN+MAX_CHANGES+2)-1:0]   n_o
);

  localparam int SW = $clog2(KMER_LEN + MAX_CHANGES + 2);

  // True when the positions below can still bring the base count up to the
  // target without exceeding the change budget.
  function automatic logic can_fin(input logic [SW-1:0] d, input logic [SW-1:0] n,
                                   input logic [SW-1:0] b, input logic [SW-1:0] o);
    logic [SW-1:0] m;
    logic [SW-1:0] room;
    m    = SW'(MAX_CHANGES);
    room = m - d;
    if (o < room) room = o;
    return (d <= m) && ((n + b + room) >= m);
  endfunction

  logic               keep_ok, chg_ok;
  logic [DIGIT_W-1:0] cand;
  logic               cand_ok;

  assign keep_ok = can_fin(d_i, n_i + SW'(is_base(kc_i)), bb_i, ob_i);
  assign chg_ok  = can_fin(d_i + SW'(1), n_i + SW'(1), bb_i, ob_i);

  always_comb begin
    found_o = 1'b0;
    code_o  = kc_i;
    cand    = '0;
    cand_ok = 1'b0;
    for (int c = 7; c >= 0; c--) begin
      cand    = DIGIT_W'(c);
      cand_ok = ({1'b0, cand} >= floor_i) &&
                (((cand == kc_i) && keep_ok) ||
                 ((cand != kc_i) && is_base(cand) && chg_ok));
      if (cand_ok) begin
        found_o = 1'b1;
        code_o  = cand;
      end
    end
  end

  assign d_o = (code_o == kc_i) ? d_i : d_i + SW'(1);
  assign n_o = (code_o == kc_i) ? n_i + SW'(is_base(kc_i)) : n_i + SW'(1);

endmodule

// ===== design/hbke_seq.sv =====
// Sequencer: count, scan and fill passes over the digit rotators, result register.
// Depends on hbke_pkg and instantiates hbke_pick.
module hbke_seq import hbke_pkg::*; #(
  parameter int KMER_LEN    = KMER_LEN_DEF,
  parameter int MAX_CHANGES = MAX_CHANGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  hbke_req_t                   req_i,
  output logic                        busy,
  output logic                        res_valid_o,
  output hbke_res_t                   res_o,
  output sh_ctrl_t                    sh_ctrl_o,
  input  sh_view_t                    view_i,
  input  logic [DIGIT_W*KMER_LEN-1:0] rot_v_i
);

  localparam int VW = DIGIT_W * KMER_LEN;
  localparam int SW = $clog2(KMER_LEN + MAX_CHANGES + 2);
  localparam int PW = $clog2(KMER_LEN);
  localparam logic [PW-1:0] POS_TOP = PW'(KMER_LEN - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COUNT = 5'b00010,
    S_FILL  = 5'b00100,
    S_SETUP = 5'b01000,
    S_SCAN  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic            ld_q, ld_d;
  logic            active_q, active_d;
  logic            pend_q, pend_d;
  logic            res_valid_q, res_valid_d;
  logic [SW-1:0]   da_q, da_d, na_q, na_d;
  logic [SW-1:0]   d_q, d_d, n_q, n_d;
  logic [SW-1:0]   bb_q, bb_d, ob_q, ob_d;
  logic [VW-1:0]   out_var_q, out_var_d;
  hbke_res_t       res_q, res_d;

  logic [VW+FIELD_W-1:0] var_pad;
  logic [SW-1:0]         scan_d, scan_n, fill_bb, fill_ob;
  logic [DIGIT_W-1:0]    pk_kc;
  logic [DIGIT_W:0]      pk_floor;
  logic [SW-1:0]         pk_d, pk_n, pk_bb, pk_ob;
  logic                  pk_found;
  logic [DIGIT_W-1:0]    pk_code;
  logic [SW-1:0]         pk_d2, pk_n2;

  assign var_pad = {{FIELD_W{1'b0}}, out_var_q};

  // Counts above the scan position, and counts below the fill position.
  assign scan_d  = da_q - SW'(view_i.v0 != view_i.k0);
  assign scan_n  = na_q - SW'(is_base(view_i.v0));
  assign fill_bb = bb_q - SW'(is_base(view_i.ktop));
  assign fill_ob = ob_q - SW'(!is_base(view_i.ktop));

  always_comb begin
    if (state_q == S_FILL) begin
      pk_kc    = view_i.ktop;
      pk_floor = '0;
      pk_d     = d_q;
      pk_n     = n_q;
      pk_bb    = fill_bb;
      pk_ob    = fill_ob;
    end else begin
      pk_kc    = view_i.k0;
      pk_floor = {1'b0, view_i.v0} + (DIGIT_W+1)'(1);
      pk_d     = scan_d;
      pk_n     = scan_n;
      pk_bb    = bb_q;
      pk_ob    = ob_q;
    end
  end

  hbke_pick #(
    .KMER_LEN    (KMER_LEN),
    .MAX_CHANGES (MAX_CHANGES)
  ) u_pick (
    .kc_i    (pk_kc),
    .floor_i (pk_floor),
    .d_i     (pk_d),
    .n_i     (pk_n),
    .bb_i    (pk_bb),
    .ob_i    (pk_ob),
    .found_o (pk_found),
    .code_o  (pk_code),
    .d_o     (pk_d2),
    .n_o     (pk_n2)
  );

  always_comb begin
    state_d         = state_q;
    pos_d           = pos_q;
    ld_d            = ld_q;
    active_d        = active_q;
    pend_d          = pend_q;
    res_valid_d     = 1'b0;
    da_d            = da_q;
    na_d            = na_q;
    d_d             = d_q;
    n_d             = n_q;
    bb_d            = bb_q;
    ob_d            = ob_q;
    out_var_d       = out_var_q;
    res_d           = res_q;
    sh_ctrl_o.op    = SH_HOLD;
    sh_ctrl_o.digit = pk_code;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.req_type == REQ_LOAD) begin
            sh_ctrl_o.op = SH_LOAD;
            bb_d    = '0;
            ob_d    = '0;
            pos_d   = '0;
            ld_d    = 1'b1;
            state_d = S_COUNT;
          end else if (active_q && pend_q) begin
            state_d = S_SETUP;
          end else begin
            res_valid_d     = 1'b1;
            res_d.variation = '0;
            res_d.is_last   = 1'b0;
            res_d.none_left = 1'b1;
            active_d        = 1'b0;
          end
        end
      end
      S_COUNT: begin
        sh_ctrl_o.op = SH_RIGHT;
        bb_d = bb_q + SW'(is_base(view_i.k0));
        ob_d = ob_q + SW'(!is_base(view_i.k0));
        if (pos_q == POS_TOP) begin
          d_d     = '0;
          n_d     = '0;
          state_d = S_FILL;
        end else begin
          pos_d = pos_q + PW'(1);
        end
      end
      S_FILL: begin
        sh_ctrl_o.op = SH_LEFT;
        if (!pk_found) begin
          // Only the top position of a load can fail: the set is empty.
          res_valid_d     = 1'b1;
          res_d.variation = '0;
          res_d.is_last   = 1'b0;
          res_d.none_left = 1'b1;
          active_d        = 1'b0;
          state_d         = S_IDLE;
        end else begin
          d_d  = pk_d2;
          n_d  = pk_n2;
          bb_d = fill_bb;
          ob_d = fill_ob;
          if (pos_q == '0) begin
            if (ld_q) begin
              ld_d    = 1'b0;
              state_d = S_SETUP;
            end else begin
              res_valid_d     = 1'b1;
              res_d.variation = var_pad[FIELD_W-1:0];
              res_d.is_last   = 1'b0;
              res_d.none_left = 1'b0;
              pend_d          = 1'b1;
              active_d        = 1'b1;
              state_d         = S_IDLE;
            end
          end else begin
            pos_d = pos_q - PW'(1);
          end
        end
      end
      S_SETUP: begin
        out_var_d = rot_v_i;
        da_d      = d_q;
        na_d      = n_q;
        bb_d      = '0;
        ob_d      = '0;
        pos_d     = '0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (pk_found) begin
          sh_ctrl_o.op = SH_SET0;
          d_d = pk_d2;
          n_d = pk_n2;
          if (pos_q == '0) begin
            res_valid_d     = 1'b1;
            res_d.variation = var_pad[FIELD_W-1:0];
            res_d.is_last   = 1'b0;
            res_d.none_left = 1'b0;
            pend_d          = 1'b1;
            active_d        = 1'b1;
            state_d         = S_IDLE;
          end else begin
            pos_d   = pos_q - PW'(1);
            state_d = S_FILL;
          end
        end else begin
          sh_ctrl_o.op = SH_RIGHT;
          da_d = scan_d;
          na_d = scan_n;
          bb_d = bb_q + SW'(is_base(view_i.k0));
          ob_d = ob_q + SW'(!is_base(view_i.k0));
          if (pos_q == POS_TOP) begin
            res_valid_d     = 1'b1;
            res_d.variation = var_pad[FIELD_W-1:0];
            res_d.is_last   = 1'b1;
            res_d.none_left = 1'b0;
            pend_d          = 1'b0;
            active_d        = 1'b1;
            state_d         = S_IDLE;
          end else begin
            pos_d = pos_q + PW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      ld_q        <= 1'b0;
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      da_q        <= '0;
      na_q        <= '0;
      d_q         <= '0;
      n_q         <= '0;
      bb_q        <= '0;
      ob_q        <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      ld_q        <= ld_d;
      active_q    <= active_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      da_q        <= da_d;
      na_q        <= na_d;
      d_q         <= d_d;
      n_q         <= n_d;
      bb_q        <= bb_d;
      ob_q        <= ob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_var_q <= out_var_d;
    res_q     <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/hbke_checker.sv =====
// Port-level checks of the enumerator and the bind that attaches them.
// Depends on hbke_pkg and on the top level's port names.
module hbke_checker import hbke_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      res_valid_o,
  input hbke_res_t res_o
);

  // An empty answer carries no member and no last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.none_left) |-> (res_o.variation == '0 && !res_o.is_last))
    else $error("none_left result with nonzero payload");

  // An accepted item either keeps the block busy or answers at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_valid_o))
    else $error("accepted item neither busy nor answered");

  // A result only appears once the block has gone idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while busy");

  // Finishing work always shows a result in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("work finished without a result");

  // Back-to-back results need an item accepted in between.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !(start && !busy)) |=> !res_valid_o)
    else $error("result without an accepted item");

endmodule

bind hamming_ball_kmer_enumerator hbke_checker u_hbke_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
